// File: rtl/core/pcstf_pkg.sv
// shared types, codes and constants of the pcm sample to float converter
package pcstf_pkg;

    // sample format codes
    localparam logic [2:0] FMT_U8  = 3'd0;
    localparam logic [2:0] FMT_S16 = 3'd1;
    localparam logic [2:0] FMT_S32 = 3'd2;
    localparam logic [2:0] FMT_S64 = 3'd3;
    localparam logic [2:0] FMT_F32 = 3'd4;
    localparam logic [2:0] FMT_F64 = 3'd5;

    // configuration register indexes
    localparam logic REG_FORMAT   = 1'b0;
    localparam logic REG_CHANNELS = 1'b1;

    localparam logic [2:0] FORMAT_RESET   = FMT_S16;
    localparam logic [3:0] CHANNELS_RESET = 4'd2;
    localparam logic [3:0] MAX_CHANNELS   = 4'd8;

    // work kinds
    localparam logic [1:0] KIND_CONST = 2'd0;
    localparam logic [1:0] KIND_INT   = 2'd1;
    localparam logic [1:0] KIND_DBL   = 2'd2;

    localparam logic [31:0] ONE_BITS     = 32'h3F80_0000;
    localparam logic [31:0] NEG_ONE_BITS = 32'hBF80_0000;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    typedef struct packed {
        logic [63:0] raw_sample;
        logic [11:0] sample_index;
        logic [2:0]  channel_index;
    } in_t;

    typedef struct packed {
        logic [31:0] float_bits;
        logic [14:0] dest_index;
    } out_t;

    // classified request between front and back
    typedef struct packed {
        logic [1:0]        kind;
        logic              sign;
        logic              dround;
        logic [63:0]       mag;
        logic signed [11:0] expo;
        logic [5:0]        rsh;
        logic [31:0]       cbits;
        logic [14:0]       dest;
    } work_t;

    // one back pipeline stage
    typedef struct packed {
        logic [1:0]        kind;
        logic              sign;
        logic              dround;
        logic [63:0]       m;
        logic signed [11:0] e;
        logic [31:0]       cbits;
        logic [14:0]       dest;
    } stage_t;

endpackage

// File: rtl/core/pcm_sample_to_float_converter.sv
// top level of the pcm sample to float converter
//
//  channel   signals                          direction  handshake
//  request   start, busy, sample              in         taken when start && !busy
//  result    done, result                     out        one-cycle strobe, no back pressure
//  config    cfg_we, cfg_index, cfg_data      in         written when cfg_we is high
//
// one request per cycle sustained; a result passes through
// the queue slot, the three normalize/round pipeline registers and the output register
// the queue between front and back is drained every cycle, so busy stays low
// reset clears the queue pointers, the pipeline valid bits and loads the defaults
// (format s16, two channels)
module pcm_sample_to_float_converter
    import pcstf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  in_t        sample,
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [3:0] cfg_data,
    output logic       done,
    output out_t       result
);

    logic [2:0] format_reg;
    logic [2:0] format_next;
    logic [3:0] channels_reg;
    logic [3:0] channels_next;
    work_t      front_work;
    work_t      queue_work;
    logic       queue_empty;
    logic       queue_full;
    logic       accept;

    // configuration registers
    always_comb
    begin
        format_next   = format_reg;
        channels_next = channels_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_FORMAT:   format_next   = cfg_data[2:0];
                REG_CHANNELS: channels_next = cfg_data;
                default:      format_next   = format_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            format_reg   <= FORMAT_RESET;
            channels_reg <= CHANNELS_RESET;
        end
        else
        begin
            format_reg   <= format_next;
            channels_reg <= channels_next;
        end
    end

    assign busy   = queue_full;
    assign accept = start && !queue_full;

    // classify the request
    pcstf_front u_front
    (
        .sample (sample),
        .fmt    (format_reg),
        .chans  (channels_reg),
        .work   (front_work)
    );

    // decouple classify from execute
    pcstf_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (front_work),
        .pop       (!queue_empty),
        .pop_data  (queue_work),
        .empty     (queue_empty),
        .full      (queue_full)
    );

    // normalize, round, pack
    pcstf_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (!queue_empty),
        .work     (queue_work),
        .done     (done),
        .result   (result)
    );

endmodule

// File: rtl/core/pcstf_front.sv
// front end: classifies a request into a work descriptor
module pcstf_front
    import pcstf_pkg::*;
(
    input  in_t        sample,
    input  logic [2:0] fmt,
    input  logic [3:0] chans,
    output work_t      work
);

    logic [63:0]        val;
    logic [63:0]        magv;
    logic               neg;
    logic               is_int;
    logic signed [11:0] ebase;
    logic [10:0]        de;
    logic [51:0]        df;
    logic signed [11:0] dexp;
    logic signed [11:0] dsh;
    logic [7:0]         fexp;
    logic [3:0]         ch_eff;
    logic [15:0]        prod;

    always_comb
    begin
        ch_eff = (chans > MAX_CHANNELS) ? MAX_CHANNELS : chans;
        prod   = 16'(sample.sample_index) * 16'(ch_eff) + 16'(sample.channel_index);
    end

    always_comb
    begin
        work        = '0;
        work.kind   = KIND_CONST;
        work.dest   = prod[14:0];
        val         = '0;
        is_int      = 1'b0;
        ebase       = '0;
        de          = sample.raw_sample[62:52];
        df          = sample.raw_sample[51:0];
        dexp        = $signed({1'b0, de}) - 12'sd896;
        dsh         = 12'sd1 - dexp;
        fexp        = sample.raw_sample[30:23];
        case (fmt)
            FMT_U8:
            begin
                val    = {{56{~sample.raw_sample[7]}}, ~sample.raw_sample[7],
                          sample.raw_sample[6:0]};
                ebase  = 12'sd183;
                is_int = 1'b1;
            end
            FMT_S16:
            begin
                val    = {{48{sample.raw_sample[15]}}, sample.raw_sample[15:0]};
                ebase  = 12'sd175;
                is_int = 1'b1;
            end
            FMT_S32:
            begin
                val    = {{32{sample.raw_sample[31]}}, sample.raw_sample[31:0]};
                ebase  = 12'sd159;
                is_int = 1'b1;
            end
            FMT_S64:
            begin
                val         = sample.raw_sample;
                ebase       = 12'sd127;
                is_int      = 1'b1;
                work.dround = 1'b1;
            end
            FMT_F32:
            begin
                if (fexp == 8'hFF)
                    work.cbits = '0;
                else if (sample.raw_sample[30:0] > ONE_BITS[30:0])
                    work.cbits = sample.raw_sample[31] ? NEG_ONE_BITS : ONE_BITS;
                else
                    work.cbits = sample.raw_sample[31:0];
            end
            FMT_F64:
            begin
                if (de == 11'h7FF)
                    work.cbits = '0;
                else if (de > 11'd1150 || (de == 11'd1150 && (&df[51:28])))
                    work.cbits = '0;
                else if (de > 11'd1023 || (de == 11'd1023 && df != '0))
                    work.cbits = sample.raw_sample[63] ? NEG_ONE_BITS : ONE_BITS;
                else
                begin
                    work.kind = KIND_DBL;
                    work.sign = sample.raw_sample[63];
                    work.mag  = {(de != '0), df, 11'b0};
                    if (dexp >= 12'sd1)
                    begin
                        work.expo = dexp;
                        work.rsh  = '0;
                    end
                    else
                    begin
                        work.expo = '0;
                        work.rsh  = (dsh > 12'sd63) ? 6'd63 : dsh[5:0];
                    end
                end
            end
            default:
            begin
                work.cbits = '0;
            end
        endcase
        neg  = val[63];
        magv = neg ? (~val + 64'd1) : val;
        if (is_int)
        begin
            if (magv == '0)
            begin
                work.cbits  = '0;
                work.dround = 1'b0;
            end
            else
            begin
                work.kind = KIND_INT;
                work.sign = neg;
                work.mag  = magv;
                work.expo = ebase;
            end
        end
    end

endmodule

// File: rtl/core/pcstf_queue.sv
// short request queue between front and back
module pcstf_queue
    import pcstf_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  work_t push_data,
    input  logic  pop,
    output work_t pop_data,
    output logic  empty,
    output logic  full
);

    work_t               slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_next;
    logic [QPTR_W:0]     count_reg;
    logic [QPTR_W:0]     count_next;
    logic                do_push;
    logic                do_pop;

    assign empty    = (count_reg == '0);
    assign full     = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (QPTR_W+1)'(do_push) - (QPTR_W+1)'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

endmodule

// File: rtl/core/pcstf_back.sv
// back end: normalize, round and pack pipeline
module pcstf_back
    import pcstf_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    input  work_t work,
    output logic  done,
    output out_t  result
);

    stage_t s1_reg, s1_next;
    stage_t s2_reg, s2_next;
    stage_t s3_reg, s3_next;
    logic   v1_reg, v2_reg, v3_reg, done_reg;
    out_t   result_reg, result_next;
    logic   sticky;
    logic   up53;
    logic   up24;
    logic [53:0] r53;
    logic [30:0] packed_mag;

    // stage 1: subnormal right shift or coarse normalize
    always_comb
    begin
        s1_next         = '0;
        s1_next.kind    = work.kind;
        s1_next.sign    = work.sign;
        s1_next.dround  = work.dround;
        s1_next.cbits   = work.cbits;
        s1_next.dest    = work.dest;
        s1_next.m       = work.mag;
        s1_next.e       = work.expo;
        sticky          = |(work.mag & ~({64{1'b1}} << work.rsh));
        if (work.kind == KIND_DBL)
            s1_next.m = (work.mag >> work.rsh) | {63'b0, sticky};
        else if (work.kind == KIND_INT)
        begin
            if (s1_next.m[63:32] == '0)
            begin
                s1_next.m = s1_next.m << 32;
                s1_next.e = s1_next.e - 12'sd32;
            end
            if (s1_next.m[63:48] == '0)
            begin
                s1_next.m = s1_next.m << 16;
                s1_next.e = s1_next.e - 12'sd16;
            end
            if (s1_next.m[63:56] == '0)
            begin
                s1_next.m = s1_next.m << 8;
                s1_next.e = s1_next.e - 12'sd8;
            end
        end
    end

    // stage 2: fine normalize
    always_comb
    begin
        s2_next = s1_reg;
        if (s1_reg.kind == KIND_INT)
        begin
            if (s2_next.m[63:60] == '0)
            begin
                s2_next.m = s2_next.m << 4;
                s2_next.e = s2_next.e - 12'sd4;
            end
            if (s2_next.m[63:62] == '0)
            begin
                s2_next.m = s2_next.m << 2;
                s2_next.e = s2_next.e - 12'sd2;
            end
            if (!s2_next.m[63])
            begin
                s2_next.m = s2_next.m << 1;
                s2_next.e = s2_next.e - 12'sd1;
            end
        end
    end

    // stage 3: round to double precision first where needed
    always_comb
    begin
        s3_next = s2_reg;
        up53    = s2_reg.m[10] && ((|s2_reg.m[9:0]) || s2_reg.m[11]);
        r53     = {1'b0, s2_reg.m[63:11]} + 54'(up53);
        if (s2_reg.dround)
        begin
            if (r53[53])
            begin
                s3_next.m = {1'b1, 63'b0};
                s3_next.e = s2_reg.e + 12'sd1;
            end
            else
                s3_next.m = {r53[52:0], 11'b0};
        end
    end

    // stage 4: round to single and pack
    always_comb
    begin
        up24       = s3_reg.m[39] && ((|s3_reg.m[38:0]) || s3_reg.m[40]);
        packed_mag = {s3_reg.e[7:0], s3_reg.m[62:40]} + 31'(up24);
        result_next.dest_index = s3_reg.dest;
        if (s3_reg.kind == KIND_CONST)
            result_next.float_bits = s3_reg.cbits;
        else
            result_next.float_bits = {s3_reg.sign, packed_mag};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= in_valid;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            done_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg     <= s1_next;
        s2_reg     <= s2_next;
        s3_reg     <= s3_next;
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// File: rtl/core/pcstf_checker.sv
// port-level checks of the pcm sample to float converter
module pcstf_checker
    import pcstf_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done,
    input out_t result
);

    // every taken request yields a result after fixed latency
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##5 done)
        else $error("missing result");

    // no result without a request
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 5))
        else $error("result without request");

    // results stay within -1..1 and are never non-finite
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.float_bits[30:0] <= ONE_BITS[30:0]))
        else $error("result out of range");

    // back end never stalls so the queue never fills
    assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("queue filled");

endmodule

bind pcm_sample_to_float_converter pcstf_checker u_pcstf_checker
(
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);

// File: verif/tb_pcm_sample_to_float_converter.sv
// testbench of the pcm sample to float converter: bit-exact prediction and result checks
`timescale 1ns / 1ps

module tb_pcm_sample_to_float_converter;
    import pcstf_pkg::*;

    localparam int RAND_PER_PHASE = 128;
    localparam int SETTLE_CYCLES  = 10;     // keeps some margin beyond the result latency
    localparam int STALL_LIMIT    = 5000;   // cycles with no request and no result

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       start = 1'b0;
    logic       busy;
    in_t        sample = '0;
    logic       cfg_we = 1'b0;
    logic       cfg_index = REG_FORMAT;
    logic [3:0] cfg_data = '0;
    logic       done;
    out_t       result;

    // requests waiting for the driver, results waiting for the block
    in_t  pending_samples[$];
    out_t expected_floats[$];

    // register copies as the block should hold them
    logic [2:0] fmt_reg = FORMAT_RESET;
    logic [3:0] chan_reg = CHANNELS_RESET;

    int err_cnt = 0;
    int req_cnt = 0;
    int res_cnt = 0;
    int quiet_cycles = 0;
    int burst_left = 0;
    int gap_left = 0;

    pcm_sample_to_float_converter i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .sample    (sample),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .done      (done),
        .result    (result)
    );

    always #1 clk = ~clk;

    // ------------------------------------------------------------------
    // bit-level float arithmetic
    // ------------------------------------------------------------------

    function automatic int top_bit(logic [127:0] m);
        int p;
        p = -1;
        for (int i = 0; i < 128; i++)
        begin
            if (m[i])
                p = i;
        end
        return p;
    endfunction

    // shift right with round to nearest, ties to even
    function automatic logic [127:0] shr_round_even(logic [127:0] m, int sh);
        logic [127:0] q;
        logic [127:0] rem;
        logic [127:0] half;
        if (sh <= 0)
            return m << (-sh);
        if (sh >= 120)
            return '0;
        q    = m >> sh;
        rem  = m & ((128'd1 << sh) - 128'd1);
        half = 128'd1 << (sh - 1);
        if (rem > half || (rem == half && q[0]))
            q = q + 128'd1;
        return q;
    endfunction

    // single-precision bits of (-1)^neg * m * 2^e, magnitude at most one
    function automatic logic [31:0] pack_single(logic neg, logic [127:0] m, int e);
        int           p;
        int           sh;
        int           lsb_exp;
        logic [127:0] q;
        logic [7:0]   bexp;
        if (m == '0)
            return {neg, 31'd0};
        p  = top_bit(m);
        sh = p - 23;
        // below the normal range the lsb weight is pinned at 2^-149
        if (-149 - e > sh)
            sh = -149 - e;
        q       = shr_round_even(m, sh);
        lsb_exp = e + sh;
        if (q[24])
        begin
            q       = q >> 1;
            lsb_exp = lsb_exp + 1;
        end
        if (q < 128'h80_0000)
            return {neg, 8'd0, q[22:0]};
        bexp = 8'(lsb_exp + 150);
        return {neg, bexp, q[22:0]};
    endfunction

    function automatic logic [31:0] unit_float(logic [63:0] raw, logic [2:0] fmt);
        logic         neg;
        logic [127:0] m;
        logic [63:0]  mag;
        logic [10:0]  dexp;
        logic [51:0]  dfrac;
        logic [7:0]   fexp;
        int           p;
        case (fmt)
            FMT_U8:
            begin
                neg = raw[7:0] < 8'd128;
                m   = neg ? 128'(8'd128 - raw[7:0]) : 128'(raw[7:0] - 8'd128);
                return pack_single(neg, m, -7);
            end
            FMT_S16:
            begin
                neg = raw[15];
                m   = neg ? 128'(17'h10000 - 17'(raw[15:0])) : 128'(raw[15:0]);
                return pack_single(neg, m, -15);
            end
            FMT_S32:
            begin
                // exact in double, so a single rounding to single
                neg = raw[31];
                m   = neg ? 128'(33'h1_0000_0000 - 33'(raw[31:0])) : 128'(raw[31:0]);
                return pack_single(neg, m, -31);
            end
            FMT_S64:
            begin
                // first rounded to 53 bits as a double, then again to 24
                neg = raw[63];
                mag = neg ? (64'd0 - raw) : raw;
                m   = 128'(mag);
                if (mag != '0)
                begin
                    p = top_bit(m);
                    if (p > 52)
                        m = shr_round_even(m, p - 52) << (p - 52);
                end
                return pack_single(neg, m, -63);
            end
            FMT_F32:
            begin
                fexp = raw[30:23];
                if (fexp == 8'hFF)
                    return '0;
                if (fexp > 8'd127 || (fexp == 8'd127 && raw[22:0] != '0))
                    return raw[31] ? NEG_ONE_BITS : ONE_BITS;
                return raw[31:0];
            end
            FMT_F64:
            begin
                dexp  = raw[62:52];
                dfrac = raw[51:0];
                if (dexp == 11'h7FF)
                    return '0;
                // would round to infinity in single
                if (dexp > 11'd1150 || (dexp == 11'd1150 && dfrac >= 52'hF_FFFF_F000_0000))
                    return '0;
                if (dexp > 11'd1023 || (dexp == 11'd1023 && dfrac != '0))
                    return raw[63] ? NEG_ONE_BITS : ONE_BITS;
                if (dexp == '0)
                    return pack_single(raw[63], 128'(dfrac), -1074);
                return pack_single(raw[63], {76'd1, dfrac}, int'(dexp) - 1075);
            end
            default:
                return '0;
        endcase
    endfunction

    function automatic out_t convert_request(in_t req, logic [2:0] fmt, logic [3:0] chans);
        out_t       r;
        logic [3:0] n;
        n            = (chans > MAX_CHANNELS) ? MAX_CHANNELS : chans;
        r.float_bits = unit_float(req.raw_sample, fmt);
        r.dest_index = 15'(16'(req.sample_index) * 16'(n) + 16'(req.channel_index));
        return r;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    // raw patterns that reach the interesting corners of every format
    function automatic logic [63:0] random_raw();
        logic [63:0] r;
        r = {$urandom(), $urandom()};
        case ($urandom_range(0, 9))
            0: r[62:52] = 11'($urandom_range(1013, 1023));          // double near one
            1: r[30:23] = 8'($urandom_range(117, 127));             // float near one
            2: r[62:52] = 11'h7FF;                                  // double nan or inf
            3: r[30:23] = 8'hFF;                                    // float nan or inf
            4: r[62:52] = 11'($urandom_range(860, 900));            // single subnormal range
            5: r[30:23] = 8'd0;                                     // float subnormal
            6:
            begin
                // right around the single overflow edge
                r[62:52] = 11'd1150;
                r[51:28] = 24'hFF_FFFF - 24'($urandom_range(0, 1));
            end
            7: r = {{40{r[23]}}, r[23:0]};                          // small signed values
            8: r[62:52] = 11'($urandom_range(0, 3));                // double subnormal or tiny normal
            default: ;
        endcase
        return r;
    endfunction

    function automatic in_t make_request(logic [63:0] raw);
        in_t req;
        req.raw_sample    = raw;
        req.sample_index  = 12'($urandom());
        req.channel_index = 3'($urandom());
        return req;
    endfunction

    task automatic write_reg(logic idx, logic [3:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // drained: nothing queued, nothing offered, nothing outstanding
    task automatic wait_drained();
        while (pending_samples.size() != 0 || start || expected_floats.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // request driver: bursts with random gaps
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else if (!(start && busy))
        begin
            if (gap_left > 0)
            begin
                gap_left = gap_left - 1;
                start <= 1'b0;
            end
            else if (pending_samples.size() != 0)
            begin
                sample <= pending_samples.pop_front();
                start  <= 1'b1;
                if (burst_left <= 1)
                begin
                    burst_left = $urandom_range(1, 40);
                    // about a third of the bursts run straight into the next one
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
                end
                else
                begin
                    burst_left = burst_left - 1;
                end
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: register copies, prediction, result checks, watchdog
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            quiet_cycles = quiet_cycles + 1;
            if (cfg_we)
            begin
                if (cfg_index == REG_FORMAT)
                    fmt_reg <= cfg_data[2:0];
                else
                    chan_reg <= cfg_data;
            end
            if (start && !busy)
            begin
                expected_floats.push_back(convert_request(sample, fmt_reg, chan_reg));
                req_cnt = req_cnt + 1;
                quiet_cycles = 0;
            end
            if (done)
            begin
                quiet_cycles = 0;
                res_cnt = res_cnt + 1;
                if (expected_floats.size() == 0)
                begin
                    $error("result with no request outstanding: float_bits %h dest_index %0d",
                           result.float_bits, result.dest_index);
                    err_cnt = err_cnt + 1;
                end
                else
                begin
                    out_t exp_r;
                    exp_r = expected_floats.pop_front();
                    if (result.float_bits !== exp_r.float_bits)
                    begin
                        $error("float_bits mismatch: expected %h actual %h",
                               exp_r.float_bits, result.float_bits);
                        err_cnt = err_cnt + 1;
                    end
                    if (result.dest_index !== exp_r.dest_index)
                    begin
                        $error("dest_index mismatch: expected %0d actual %0d",
                               exp_r.dest_index, result.dest_index);
                        err_cnt = err_cnt + 1;
                    end
                end
            end
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("timeout: no request or result for %0d cycles", STALL_LIMIT);
                $display("pcm_sample_to_float_converter verification failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------

    // corner raw values: integer extremes, float limits, specials, zero signs
    localparam int N_CORNERS = 22;
    localparam logic [63:0] CORNERS [N_CORNERS] = '{
        64'h0000_0000_0000_0000, 64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF,
        64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0080, 64'h0000_0000_0000_007F,
        64'h0000_0000_0000_8000, 64'h0000_0000_7FFF_FFFF, 64'h0000_0000_8000_0000,
        64'h0000_0000_3F80_0001, 64'h0000_0000_BF80_0001, 64'h0000_0000_7F80_0000,
        64'h0000_0000_7FC0_0000, 64'h0000_0000_0000_0001, 64'h3FF0_0000_0000_0001,
        64'hBFF0_0000_0000_0000, 64'hFFF8_0000_0000_0000, 64'h47EF_FFFF_F000_0000,
        64'hC7EF_FFFF_E000_0000, 64'h36A0_0000_0000_0000, 64'h3690_0000_0000_0000,
        64'h3FEF_FFFF_F000_0000
    };

    // format and channel settings per phase; the first phase keeps the reset values
    localparam int N_PHASES = 13;
    localparam logic [3:0] PHASE_FMT  [N_PHASES] = '{4'd1, 4'd0, 4'd2, 4'd3, 4'd4, 4'd5,
        4'hF, 4'd6, 4'd1, 4'd5, 4'd3, 4'd2, 4'd4};
    localparam logic [3:0] PHASE_CHAN [N_PHASES] = '{4'd2, 4'd1, 4'd8, 4'd15, 4'd0, 4'd3,
        4'd5, 4'd8, 4'd7, 4'd8, 4'd1, 4'd4, 4'd8};

    initial
    begin
        in_t req;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            if (ph != 0)
            begin
                wait_drained();
                write_reg(REG_FORMAT, PHASE_FMT[ph]);
                write_reg(REG_CHANNELS, PHASE_CHAN[ph]);
            end
            // directed corners, with index extremes on the first two
            for (int k = 0; k < N_CORNERS; k++)
            begin
                req = make_request(CORNERS[k]);
                if (k == 0)
                begin
                    req.sample_index  = '0;
                    req.channel_index = '0;
                end
                if (k == 1)
                begin
                    req.sample_index  = '1;
                    req.channel_index = '1;
                end
                pending_samples.push_back(req);
            end
            for (int k = 0; k < RAND_PER_PHASE; k++)
                pending_samples.push_back(make_request(random_raw()));
        end

        wait_drained();
        $display("covered %0d requests and %0d results over %0d register settings",
                 req_cnt, res_cnt, N_PHASES);
        $display("all formats incl. unsupported codes, channel counts 0 to 15, %0d errors",
                 err_cnt);
        if (err_cnt == 0 && expected_floats.size() == 0)
            $display("pcm_sample_to_float_converter verification clean");
        else
            $display("pcm_sample_to_float_converter verification failed");
        $finish;
    end

endmodule
